/* hdl/iac_pkg.sv */
// shared types and constants for the interval peak admission check
// operation codes, controller states and the command/status structs
// no dependencies
package iac_pkg;

  localparam int CORE_W     = 8;
  localparam int PROC_W     = 32;
  localparam int OUT_PEAK_W = 6;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OUT_RD,
    ST_OUT_CHK,
    ST_IN_RUN,
    ST_IN_DRAIN,
    ST_OUT_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic query_start;
    logic cap_t;
    logic acc_issue;
    logic peak_upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic t_sel;
  } status_t;

endpackage

/* hdl/iac_dpath.sv */
// datapath: task table memory, query window, overlap level and peak registers
// driven by commands from iac_ctrl; depends on iac_pkg
module iac_dpath import iac_pkg::*; #(
  parameter int MAX_TASKS = 32,
  parameter int TIME_BITS = 48,
  localparam int AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
  localparam int CNT_W = $clog2(MAX_TASKS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [AW-1:0]         rd_addr,
  input  logic                  cfg_wr_en,
  input  logic [CORE_W-1:0]     cfg_wr_data,
  input  logic [TIME_BITS-1:0]  task_start,
  input  logic [TIME_BITS-1:0]  task_finish,
  input  logic [TIME_BITS-1:0]  earliest_start,
  input  logic [TIME_BITS-1:0]  anchor_time,
  input  logic [PROC_W-1:0]     proc_time,
  output logic [CNT_W-1:0]      count,
  output status_t               status,
  output logic                  fits,
  output logic [OUT_PEAK_W-1:0] peak_usage,
  output logic                  table_overflow
);

  localparam int PW    = (TIME_BITS < PROC_W) ? TIME_BITS : PROC_W;
  localparam int LVL_W = CNT_W + 2;
  localparam int CMP_W = (CNT_W > CORE_W) ? CNT_W : CORE_W;

  logic [TIME_BITS-1:0] start_mem [MAX_TASKS];
  logic [TIME_BITS-1:0] finish_mem [MAX_TASKS];

  logic                    ovf;
  logic                    ovf_snap;
  logic [CORE_W-1:0]       core_count;
  logic [TIME_BITS-1:0]    lo;
  logic [TIME_BITS-1:0]    hi;
  logic [TIME_BITS-1:0]    hi_next;
  logic [TIME_BITS-1:0]    t;
  logic [TIME_BITS-1:0]    rd_s;
  logic [TIME_BITS-1:0]    rd_f;
  logic                    acc_vld;
  logic signed [LVL_W-1:0] level;
  logic signed [LVL_W-1:0] level_next;
  logic [CNT_W-1:0]        peak;
  logic [CNT_W+OUT_PEAK_W-1:0] peak_wide;
  logic [TIME_BITS-1:0]    p_ext;
  logic [TIME_BITS:0]      sum;
  logic                    full;
  logic                    sel_i;
  logic                    inc;
  logic                    dec;

  assign full = (count == CNT_W'(MAX_TASKS));

  // window end saturates at the top of the time range
  assign p_ext   = TIME_BITS'(proc_time[PW-1:0]);
  assign sum     = {1'b0, anchor_time} + {1'b0, p_ext};
  assign hi_next = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

  assign status.t_sel = (rd_s >= lo) && (rd_s <= hi);

  // t is a selected start, so t <= hi and the clipped finish is below t exactly when
  // the stored finish is
  assign sel_i      = (rd_s >= lo) && (rd_s <= hi);
  assign inc        = sel_i && (rd_s <= t);
  assign dec        = sel_i && (rd_f < t);
  assign level_next = level + LVL_W'(inc) - LVL_W'(dec);

  assign peak_wide = {{OUT_PEAK_W{1'b0}}, peak};

  always_ff @(posedge clk) begin
    if (cmd.add && !full) begin
      start_mem[count[AW-1:0]]  <= task_start;
      finish_mem[count[AW-1:0]] <= task_finish;
    end
    rd_s <= start_mem[rd_addr];
    rd_f <= finish_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      ovf        <= 1'b0;
      core_count <= CORE_W'(1);
      acc_vld    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        core_count <= cfg_wr_data;
      end
      if (cmd.clear) begin
        count <= '0;
        ovf   <= 1'b0;
      end else if (cmd.add) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      acc_vld <= cmd.acc_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      lo       <= earliest_start;
      hi       <= hi_next;
      ovf_snap <= ovf;
    end
    if (cmd.cap_t) begin
      t     <= rd_s;
      level <= '0;
    end else if (acc_vld) begin
      level <= level_next;
    end
    if (cmd.query_start) begin
      peak <= '0;
    end else if (cmd.peak_upd && ($signed({2'b00, peak}) < level)) begin
      peak <= level[CNT_W-1:0];
    end
    if (cmd.out_load) begin
      fits           <= (CMP_W'(peak) < CMP_W'(core_count));
      peak_usage     <= peak_wide[OUT_PEAK_W-1:0];
      table_overflow <= ovf_snap;
    end
  end

endmodule

/* hdl/iac_ctrl.sv */
// controller: decodes operations and sequences the nested sweep of a query
// drives iac_dpath through cmd_t; depends on iac_pkg
module iac_ctrl import iac_pkg::*; #(
  parameter int MAX_TASKS = 32,
  localparam int AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
  localparam int CNT_W = $clog2(MAX_TASKS + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic [1:0]       operation,
  output logic             req_stall,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  input  logic [CNT_W-1:0] count,
  input  status_t          status,
  output cmd_t             cmd,
  output logic [AW-1:0]    rd_addr
);

  state_t        state;
  state_t        state_next;
  logic [AW-1:0] j;
  logic [AW-1:0] j_next;
  logic [AW-1:0] i;
  logic [AW-1:0] i_next;
  logic          rsp_valid_next;
  logic          last_i;
  logic          last_j;

  assign last_i = ((CNT_W'(i) + CNT_W'(1)) == count);
  assign last_j = ((CNT_W'(j) + CNT_W'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
      j         <= '0;
      i         <= '0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      j         <= j_next;
      i         <= i_next;
    end
  end

  always_comb begin
    state_next     = state;
    j_next         = j;
    i_next         = i;
    cmd            = '0;
    rd_addr        = j;
    req_stall      = (state != ST_IDLE);
    rsp_valid_next = rsp_valid && rsp_stall;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (op_t'(operation))
            OP_CLEAR: cmd.clear = 1'b1;
            OP_ADD:   cmd.add = 1'b1;
            OP_QUERY: begin
              cmd.query_start = 1'b1;
              j_next          = '0;
              state_next      = (count == '0) ? ST_DONE : ST_OUT_RD;
            end
            default: ;
          endcase
        end
      end
      ST_OUT_RD: begin
        rd_addr    = j;
        state_next = ST_OUT_CHK;
      end
      ST_OUT_CHK: begin
        // start of entry j is on the read port now
        cmd.cap_t  = 1'b1;
        i_next     = '0;
        state_next = status.t_sel ? ST_IN_RUN : ST_OUT_NEXT;
      end
      ST_IN_RUN: begin
        rd_addr       = i;
        cmd.acc_issue = 1'b1;
        if (last_i) begin
          state_next = ST_IN_DRAIN;
        end else begin
          i_next = i + AW'(1);
        end
      end
      ST_IN_DRAIN: begin
        state_next = ST_OUT_NEXT;
      end
      ST_OUT_NEXT: begin
        cmd.peak_upd = 1'b1;
        if (last_j) begin
          state_next = ST_DONE;
        end else begin
          j_next     = j + AW'(1);
          state_next = ST_OUT_RD;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.out_load   = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_inner_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_IN_RUN |-> CNT_W'(i) < count)
    else $error("inner index beyond table fill");

  a_outer_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT_RD || state == ST_OUT_CHK) |-> CNT_W'(j) < count)
    else $error("outer index beyond table fill");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside completion");

  a_empty_query: assert property (@(posedge clk) disable iff (rst)
    (cmd.query_start && count == '0) |=> state == ST_DONE)
    else $error("query on empty table did not complete at once");
`endif

endmodule

/* hdl/interval_peak_admission_check.sv */
// top level of the interval peak admission check
// joins iac_ctrl and iac_dpath; depends on iac_pkg
//
// Request channel (req_valid / req_stall) carries one operation per transaction:
// clear the task table, add one task, or query admission. Clear, add and the
// unused code give no result. A query gives one transaction on the response
// channel (rsp_valid / rsp_stall) with fits, peak_usage and table_overflow.
// With n stored tasks, a query reads each of the n entries once as a candidate
// start and, when it lies in the window, reads all n entries again to count the
// overlap level, all through the single read port of the task table.
// req_stall is low only when the controller is idle. A finished result sits in the
// output register; while the receiver stalls, the block still takes clears, adds
// and a further query, which waits at its end until the register frees.
// Synchronous reset empties the table, clears the overflow flag, drops any pending
// result and sets core_count to 1. The user must write core_count through cfg_wr_en
// and cfg_wr_data only while the block is idle; the block does not enforce this.
module interval_peak_admission_check import iac_pkg::*; #(
  parameter int MAX_TASKS = 32,
  parameter int TIME_BITS = 48
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CORE_W-1:0]     cfg_wr_data,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [1:0]            operation,
  input  logic [TIME_BITS-1:0]  task_start,
  input  logic [TIME_BITS-1:0]  task_finish,
  input  logic [TIME_BITS-1:0]  earliest_start,
  input  logic [TIME_BITS-1:0]  anchor_time,
  input  logic [PROC_W-1:0]     proc_time,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic                  fits,
  output logic [OUT_PEAK_W-1:0] peak_usage,
  output logic                  table_overflow
);

  localparam int AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  cmd_t             cmd;
  status_t          status;
  logic [AW-1:0]    rd_addr;
  logic [CNT_W-1:0] count;

  iac_ctrl #(
    .MAX_TASKS(MAX_TASKS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .operation (operation),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .count     (count),
    .status    (status),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  iac_dpath #(
    .MAX_TASKS(MAX_TASKS),
    .TIME_BITS(TIME_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .task_start     (task_start),
    .task_finish    (task_finish),
    .earliest_start (earliest_start),
    .anchor_time    (anchor_time),
    .proc_time      (proc_time),
    .count          (count),
    .status         (status),
    .fits           (fits),
    .peak_usage     (peak_usage),
    .table_overflow (table_overflow)
  );

endmodule
